[rtl/core/sset_pkg.sv]
package sset_pkg;

	typedef enum logic [2:0] {
		KIND_INSERT = 3'd0,
		KIND_SEARCH = 3'd1,
		KIND_SHIFT  = 3'd2,
		KIND_SPLIT  = 3'd3,
		KIND_MERGE  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ROW_HOLD,
		ROW_INS,
		ROW_SHR,
		ROW_SHL,
		ROW_ADD
	} row_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SPLIT,
		ST_ROT,
		ST_MERGE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic found_any;
		logic any_eq;
	} row_flags_t;

endpackage

[rtl/core/sset_cell.sv]
module sset_cell #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  sset_pkg::row_op_t     op,
	input  logic [VALUE_BITS-1:0] din,
	input  logic                  valid,
	input  logic [VALUE_BITS-1:0] left_q,
	input  logic                  left_lt,
	input  logic [VALUE_BITS-1:0] right_q,
	output logic [VALUE_BITS-1:0] q,
	output logic                  lt,
	output logic                  le,
	output logic                  eq
);

	logic [VALUE_BITS-1:0] word_q;

	assign q  = word_q;
	assign lt = valid && ($signed(word_q) < $signed(din));
	assign le = valid && !($signed(din) < $signed(word_q));
	assign eq = valid && (word_q == din);

	always_ff @(posedge clk) begin
		case (op)
			sset_pkg::ROW_INS: begin
				if (!lt) begin
					word_q <= left_lt ? din : left_q;
				end
			end
			sset_pkg::ROW_SHR: word_q <= left_q;
			sset_pkg::ROW_SHL: word_q <= right_q;
			sset_pkg::ROW_ADD: word_q <= word_q + din;
			default: word_q <= word_q;
		endcase
	end

endmodule

[rtl/core/sset_row.sv]
module sset_row #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32,
	parameter int CW         = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  sset_pkg::row_op_t     op,
	input  logic [VALUE_BITS-1:0] din,
	input  logic [CW-1:0]         count,
	output logic [VALUE_BITS-1:0] head,
	output logic [VALUE_BITS-1:0] tail,
	output logic [VALUE_BITS-1:0] found,
	output sset_pkg::row_flags_t  flags
);

	logic [VALUE_BITS-1:0] q_w [CAPACITY];
	logic [CAPACITY-1:0]   lt_w, le_w, eq_w, valid_w;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] left_q, right_q;
		logic                  left_lt;

		assign valid_w[i] = count > CW'(i);

		if (i == 0) begin : g_first
			assign left_q  = din;
			assign left_lt = 1'b0;
		end else begin : g_mid
			assign left_q  = q_w[i-1];
			assign left_lt = lt_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_q = q_w[i];
		end else begin : g_next
			assign right_q = q_w[i+1];
		end

		sset_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
			.clk     (clk),
			.op      (op),
			.din     (din),
			.valid   (valid_w[i]),
			.left_q  (left_q),
			.left_lt (left_lt),
			.right_q (right_q),
			.q       (q_w[i]),
			.lt      (lt_w[i]),
			.le      (le_w[i]),
			.eq      (eq_w[i])
		);
	end

	assign head = q_w[0];

	always_comb begin
		found = '0;
		tail  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (le_w[i] && (i == CAPACITY - 1 || !le_w[(i+1) % CAPACITY])) begin
				found = found | q_w[i];
			end
			if (valid_w[i] && (i == CAPACITY - 1 || !valid_w[(i+1) % CAPACITY])) begin
				tail = tail | q_w[i];
			end
		end
		flags.found_any = le_w[0];
		flags.any_eq    = |eq_w;
	end

endmodule

[rtl/core/sorted_set_offset_split_merge.sv]
// Two banks, each a sorted set of distinct values held as raw words in a row of
// CAPACITY cells plus a per-bank offset. One request at a time, one result per
// request, held in an output register so the next request is taken while it
// waits. Insert, search, shift and unused kinds take one step of parallel cell
// compares and one to hand the result over. Split moves m members, one per
// cycle through the cell chain, and then sees the boundary. Merge aligns the
// offsets, then takes r rotation steps (at most count-1) to re-sort the target
// after alignment, then inserts p, the other bank's members, one per cycle.
module sorted_set_offset_split_merge #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         kind,
	input  logic               bank,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] found_value,
	output logic [6:0]         bank_count
);

	localparam int VB = VALUE_BITS;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	sset_pkg::state_t st_q, st_d;

	logic [CW-1:0] cnt_q [2];
	logic [CW-1:0] cnt_d [2];
	logic [VB-1:0] off_q [2];
	logic [VB-1:0] off_d [2];

	logic [2:0]    kind_q;
	logic          bank_q;
	logic [VB-1:0] op_q, key_q;
	logic [1:0]    status_q, status_d;
	logic [VB-1:0] found_q, found_d;

	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [31:0]   out_found_q;
	logic [6:0]    out_count_q;

	sset_pkg::row_op_t    row_op    [2];
	logic [VB-1:0]        row_din   [2];
	logic [VB-1:0]        row_head  [2];
	logic [VB-1:0]        row_tail  [2];
	logic [VB-1:0]        row_found [2];
	sset_pkg::row_flags_t row_flags [2];

	logic          slot_free, accept, load_out, b, o;
	logic [VB-1:0] op_ext, diff;

	for (genvar g = 0; g < 2; g++) begin : g_row
		sset_row #(.CAPACITY(CAPACITY), .VALUE_BITS(VB), .CW(CW)) u_row (
			.clk   (clk),
			.op    (row_op[g]),
			.din   (row_din[g]),
			.count (cnt_q[g]),
			.head  (row_head[g]),
			.tail  (row_tail[g]),
			.found (row_found[g]),
			.flags (row_flags[g])
		);
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !((st_q == sset_pkg::ST_IDLE) || (st_q == sset_pkg::ST_DONE && slot_free));
	assign op_ext    = VB'(operand);
	assign b         = bank_q;
	assign o         = ~bank_q;
	assign diff      = off_q[o] - off_q[b];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= sset_pkg::ST_IDLE;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			off_q[0]    <= '0;
			off_q[1]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			off_q <= off_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		found_q  <= found_d;
		if (accept) begin
			kind_q <= kind;
			bank_q <= bank;
			op_q   <= op_ext;
			key_q  <= op_ext - off_q[bank];
		end
		if (load_out) begin
			out_status_q <= status_q;
			out_found_q  <= 32'(found_q);
			out_count_q  <= 7'(cnt_q[bank_q]);
		end
	end

	always_comb begin
		st_d       = st_q;
		cnt_d      = cnt_q;
		off_d      = off_q;
		status_d   = status_q;
		found_d    = found_q;
		accept     = 1'b0;
		load_out   = 1'b0;
		row_op[0]  = sset_pkg::ROW_HOLD;
		row_op[1]  = sset_pkg::ROW_HOLD;
		row_din[0] = key_q;
		row_din[1] = key_q;
		unique case (st_q)
			sset_pkg::ST_IDLE: begin
				if (in_valid) begin
					accept = 1'b1;
					st_d   = sset_pkg::ST_EXEC;
				end
			end
			sset_pkg::ST_EXEC: begin
				status_d = sset_pkg::STATUS_OK;
				found_d  = '0;
				st_d     = sset_pkg::ST_DONE;
				unique case (sset_pkg::kind_t'(kind_q))
					sset_pkg::KIND_INSERT: begin
						if (!row_flags[b].any_eq) begin
							if (cnt_q[b] == FULL_CNT) begin
								status_d = sset_pkg::STATUS_FULL;
							end else begin
								row_op[b] = sset_pkg::ROW_INS;
								cnt_d[b]  = cnt_q[b] + CW'(1);
							end
						end
					end
					sset_pkg::KIND_SEARCH: begin
						if (row_flags[b].found_any) begin
							found_d = row_found[b] + off_q[b];
						end else begin
							status_d = sset_pkg::STATUS_MISS;
						end
					end
					sset_pkg::KIND_SHIFT: off_d[b] = off_q[b] + op_q;
					sset_pkg::KIND_SPLIT: begin
						off_d[o] = off_q[b];
						cnt_d[o] = '0;
						st_d     = sset_pkg::ST_SPLIT;
					end
					sset_pkg::KIND_MERGE: begin
						if (diff[VB-1]) begin
							row_op[b]  = sset_pkg::ROW_ADD;
							row_din[b] = off_q[b] - off_q[o];
							off_d[b]   = off_q[o];
						end else begin
							row_op[o]  = sset_pkg::ROW_ADD;
							row_din[o] = diff;
							off_d[o]   = off_q[b];
						end
						st_d = sset_pkg::ST_ROT;
					end
					default: ;
				endcase
			end
			sset_pkg::ST_SPLIT: begin
				row_din[o] = row_tail[b];
				if (cnt_q[b] != '0 && $signed(key_q) < $signed(row_tail[b])) begin
					row_op[o] = sset_pkg::ROW_SHR;
					cnt_d[o]  = cnt_q[o] + CW'(1);
					cnt_d[b]  = cnt_q[b] - CW'(1);
				end else begin
					st_d = sset_pkg::ST_DONE;
				end
			end
			sset_pkg::ST_ROT: begin
				row_din[b] = row_tail[b];
				if (cnt_q[b] > CW'(1) && $signed(row_tail[b]) < $signed(row_head[b])) begin
					row_op[b] = sset_pkg::ROW_SHR;
				end else begin
					st_d = sset_pkg::ST_MERGE;
				end
			end
			sset_pkg::ST_MERGE: begin
				row_din[b] = row_head[o];
				if (cnt_q[o] == '0) begin
					st_d = sset_pkg::ST_DONE;
				end else begin
					row_op[o] = sset_pkg::ROW_SHL;
					cnt_d[o]  = cnt_q[o] - CW'(1);
					if (!row_flags[b].any_eq) begin
						if (cnt_q[b] == FULL_CNT) begin
							status_d = sset_pkg::STATUS_FULL;
						end else begin
							row_op[b] = sset_pkg::ROW_INS;
							cnt_d[b]  = cnt_q[b] + CW'(1);
						end
					end
				end
			end
			sset_pkg::ST_DONE: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (in_valid) begin
						accept = 1'b1;
						st_d   = sset_pkg::ST_EXEC;
					end else begin
						st_d = sset_pkg::ST_IDLE;
					end
				end
			end
			default: st_d = sset_pkg::ST_IDLE;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign found_value = out_found_q;
	assign bank_count  = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= FULL_CNT) && (cnt_q[1] <= FULL_CNT))
		else $error("bank count above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still executing");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sset_pkg::STATUS_MISS |-> found_value == 32'sd0)
		else $error("miss result carries a value");

endmodule
